/* sv/cme_pkg.sv */
`timescale 1ns / 1ps

package cme_pkg;

  localparam int DATA_W      = 16;
  localparam int CHAR_W      = 8;
  localparam int CFG_W       = 16;
  localparam int EXP_BITS    = 16;
  localparam int CHAR_OFFSET = 96;

  localparam logic [CFG_W-1:0] MODULUS_RST = 16'd91;
  localparam logic [CFG_W-1:0] ENC_EXP_RST = 16'd5;
  localparam logic [CFG_W-1:0] DEC_EXP_RST = 16'd29;

  typedef enum logic [1:0] {
    REG_MODULUS,
    REG_ENC_EXP,
    REG_DEC_EXP
  } cfg_reg_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_RED_STEP,
    OP_BASE_FIX,
    OP_SQR_LOAD,
    OP_MUL_STEP,
    OP_ACC_LOAD,
    OP_MUL_LOAD,
    OP_EXP_NEXT,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    JC_NONE,
    JC_NO_INPUT,
    JC_CNT_NZ,
    JC_EXP_ZERO,
    JC_ECNT_NZ,
    JC_OUT_BUSY
  } jc_e;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] ST_ACCEPT   = 4'd0;
  localparam logic [PC_W-1:0] ST_RED      = 4'd1;
  localparam logic [PC_W-1:0] ST_BASE     = 4'd2;
  localparam logic [PC_W-1:0] ST_SQR_LOAD = 4'd3;
  localparam logic [PC_W-1:0] ST_SQR      = 4'd4;
  localparam logic [PC_W-1:0] ST_SQR_DONE = 4'd5;
  localparam logic [PC_W-1:0] ST_MUL_LOAD = 4'd6;
  localparam logic [PC_W-1:0] ST_MUL      = 4'd7;
  localparam logic [PC_W-1:0] ST_EXP_NEXT = 4'd8;
  localparam logic [PC_W-1:0] ST_EMIT     = 4'd9;
  localparam logic [PC_W-1:0] PROG_LAST   = ST_EMIT;

  typedef struct packed {
    op_e             op;
    jc_e             jc;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic              operation;
    logic [DATA_W-1:0] data_in;
  } cme_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] residue;
    logic [CHAR_W-1:0] char_out;
  } cme_out_t;

  typedef struct packed {
    logic cnt_nz;
    logic ecnt_nz;
    logic exp_bit;
  } cme_dstat_t;

  typedef struct packed {
    logic       in_valid;
    logic       out_busy;
    cme_dstat_t dp;
  } cme_stat_t;

  // control store: square-and-multiply with interleaved modular multiply
  function automatic uword_t uc_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      ST_ACCEPT:   w = '{op: OP_ACCEPT,   jc: JC_NO_INPUT, target: ST_ACCEPT};
      ST_RED:      w = '{op: OP_RED_STEP, jc: JC_CNT_NZ,   target: ST_RED};
      ST_BASE:     w = '{op: OP_BASE_FIX, jc: JC_NONE,     target: ST_ACCEPT};
      ST_SQR_LOAD: w = '{op: OP_SQR_LOAD, jc: JC_NONE,     target: ST_ACCEPT};
      ST_SQR:      w = '{op: OP_MUL_STEP, jc: JC_CNT_NZ,   target: ST_SQR};
      ST_SQR_DONE: w = '{op: OP_ACC_LOAD, jc: JC_EXP_ZERO, target: ST_EXP_NEXT};
      ST_MUL_LOAD: w = '{op: OP_MUL_LOAD, jc: JC_NONE,     target: ST_ACCEPT};
      ST_MUL:      w = '{op: OP_MUL_STEP, jc: JC_CNT_NZ,   target: ST_MUL};
      ST_EXP_NEXT: w = '{op: OP_EXP_NEXT, jc: JC_ECNT_NZ,  target: ST_SQR_LOAD};
      ST_EMIT:     w = '{op: OP_EMIT,     jc: JC_OUT_BUSY, target: ST_EMIT};
      default:     w = '{op: OP_ACCEPT,   jc: JC_NONE,     target: ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

/* sv/char_modular_exponentiation_core.sv */
`timescale 1ns / 1ps

// character-wise rsa modular exponentiation core
// input channel: in_valid_i / in_ready_o with in_data_i (operation, data_in);
//   operation 0 encrypts a character (offset by 96), 1 decrypts a residue
// output channel: out_valid_o / out_ready_i with out_data_o (residue, char_out)
// config port: cfg_we_i writes cfg_wdata_i to modulus (0), enc exponent (1)
//   or dec exponent (2) at once; write only while no item is in flight
// one item at a time; a 16-step base reduction, then 16 exponent bits, each
//   a square plus, for a set bit, a multiply, all on one shift-and-add
//   modular multiplier
// a new item can be taken once the result has moved to the output register
// the output register holds a finished item while the receiver stalls; the
//   sequencer waits at its emit step until that register is free
// reset returns the sequencer to its accept step, empties the output register
//   and sets modulus 91, enc exponent 5, dec exponent 29
module char_modular_exponentiation_core #(
  parameter int MOD_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  cme_pkg::cme_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cme_pkg::cme_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [cme_pkg::CFG_W-1:0] cfg_wdata_i
);
  import cme_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] modulus_q, enc_exp_q, dec_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
      enc_exp_q <= ENC_EXP_RST;
      dec_exp_q <= DEC_EXP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODULUS: modulus_q <= cfg_wdata_i;
        REG_ENC_EXP: enc_exp_q <= cfg_wdata_i;
        REG_DEC_EXP: dec_exp_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer and datapath
  uword_t            uword;
  cme_stat_t         stat;
  cme_dstat_t        dstat;
  logic [DATA_W-1:0] residue;
  logic              in_fire, out_busy, emit;

  logic              out_valid_q;
  cme_out_t          out_q;

  assign in_ready_o = uword.op == OP_ACCEPT;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit       = (uword.op == OP_EMIT) && !out_busy;

  assign stat.in_valid = in_valid_i;
  assign stat.out_busy = out_busy;
  assign stat.dp       = dstat;

  cme_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .uword_o (uword)
  );

  cme_dp #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_fire),
    .in_data_i (in_data_i),
    .modulus_i (modulus_q),
    .enc_exp_i (enc_exp_q),
    .dec_exp_i (dec_exp_q),
    .uword_i   (uword),
    .dstat_o   (dstat),
    .residue_o (residue)
  );

  // output register, holds the item while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.residue  <= residue;
      out_q.char_out <= residue[CHAR_W-1:0] + CHAR_W'(CHAR_OFFSET);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(out_q))
    else $error("pending output item overwritten or dropped");
`endif

endmodule

/* sv/cme_seq.sv */
`timescale 1ns / 1ps

module cme_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cme_pkg::cme_stat_t stat_i,
  output cme_pkg::uword_t    uword_o
);
  import cme_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            jump;

  assign uw      = uc_rom(pc_q);
  assign uword_o = uw;

  always_comb begin
    case (uw.jc)
      JC_NO_INPUT: jump = !stat_i.in_valid;
      JC_CNT_NZ:   jump = stat_i.dp.cnt_nz;
      JC_EXP_ZERO: jump = !stat_i.dp.exp_bit;
      JC_ECNT_NZ:  jump = stat_i.dp.ecnt_nz;
      JC_OUT_BUSY: jump = stat_i.out_busy;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_d = uw.target;
    end else if (pc_q == PROG_LAST) begin
      pc_d = ST_ACCEPT;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* sv/cme_dp.sv */
`timescale 1ns / 1ps

module cme_dp #(
  parameter int MOD_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  cme_pkg::cme_in_t          in_data_i,
  input  logic [cme_pkg::CFG_W-1:0] modulus_i,
  input  logic [cme_pkg::CFG_W-1:0] enc_exp_i,
  input  logic [cme_pkg::CFG_W-1:0] dec_exp_i,
  input  cme_pkg::uword_t           uword_i,
  output cme_pkg::cme_dstat_t       dstat_o,
  output logic [cme_pkg::DATA_W-1:0] residue_o
);
  import cme_pkg::*;

  localparam int W    = MOD_WIDTH;
  localparam int NW   = (MOD_WIDTH < DATA_W) ? MOD_WIDTH : DATA_W;
  localparam int CMAX = (MOD_WIDTH > EXP_BITS) ? MOD_WIDTH : EXP_BITS;
  localparam int CW   = $clog2(CMAX);
  localparam int EW   = $clog2(EXP_BITS);

  logic [W-1:0]        n_q, base_q, acc_q, prod_q, mplr_q, mcand_q, r_q;
  logic [DATA_W-1:0]   val_q;
  logic [EXP_BITS-1:0] exp_q;
  logic [CW-1:0]       cnt_q;
  logic [EW-1:0]       ecnt_q;
  logic                neg_q, zero_q;

  // input capture
  logic [W-1:0]      n_in;
  logic [DATA_W-1:0] off, mag;
  logic              under;

  assign n_in  = W'(modulus_i[NW-1:0]);
  assign off   = DATA_W'(CHAR_OFFSET);
  assign under = in_data_i.data_in < off;
  assign mag   = under ? off - in_data_i.data_in : in_data_i.data_in - off;

  // shift-in reduction step
  logic [W:0]   nx, t_red;
  logic [W-1:0] r_nxt;

  assign nx    = {1'b0, n_q};
  assign t_red = {r_q, val_q[DATA_W-1]};
  assign r_nxt = (t_red >= nx) ? W'(t_red - nx) : t_red[W-1:0];

  // interleaved modular multiply step
  logic [W:0]   d_dbl, s_add;
  logic [W-1:0] d_red, addend, p_nxt;

  assign d_dbl  = {prod_q, 1'b0};
  assign d_red  = (d_dbl >= nx) ? W'(d_dbl - nx) : d_dbl[W-1:0];
  assign addend = mplr_q[W-1] ? mcand_q : '0;
  assign s_add  = {1'b0, d_red} + {1'b0, addend};
  assign p_nxt  = (s_add >= nx) ? W'(s_add - nx) : s_add[W-1:0];

  logic [W-1:0] base_nxt;
  assign base_nxt = (neg_q && (r_q != '0)) ? n_q - r_q : r_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      n_q    <= n_in;
      zero_q <= n_in < W'(2);
      if (in_data_i.operation) begin
        val_q <= in_data_i.data_in;
        neg_q <= 1'b0;
        exp_q <= dec_exp_i;
      end else begin
        val_q <= mag;
        neg_q <= under;
        exp_q <= enc_exp_i;
      end
      r_q   <= '0;
      cnt_q <= CW'(DATA_W - 1);
    end else begin
      case (uword_i.op)
        OP_RED_STEP: begin
          r_q   <= r_nxt;
          val_q <= {val_q[DATA_W-2:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
        end
        OP_BASE_FIX: begin
          base_q <= base_nxt;
          acc_q  <= W'(1);
          ecnt_q <= EW'(EXP_BITS - 1);
        end
        OP_SQR_LOAD: begin
          mplr_q  <= acc_q;
          mcand_q <= acc_q;
          prod_q  <= '0;
          cnt_q   <= CW'(MOD_WIDTH - 1);
        end
        OP_MUL_STEP: begin
          prod_q <= p_nxt;
          mplr_q <= {mplr_q[W-2:0], 1'b0};
          cnt_q  <= cnt_q - 1'b1;
        end
        OP_ACC_LOAD: begin
          acc_q <= prod_q;
        end
        OP_MUL_LOAD: begin
          mplr_q  <= acc_q;
          mcand_q <= base_q;
          prod_q  <= '0;
          cnt_q   <= CW'(MOD_WIDTH - 1);
        end
        OP_EXP_NEXT: begin
          acc_q  <= prod_q;
          exp_q  <= {exp_q[EXP_BITS-2:0], 1'b0};
          ecnt_q <= ecnt_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign dstat_o.cnt_nz  = cnt_q != '0;
  assign dstat_o.ecnt_nz = ecnt_q != '0;
  assign dstat_o.exp_bit = exp_q[EXP_BITS-1];

  // modulus 0 or 1 gives residue 0
  assign residue_o = zero_q ? '0 : DATA_W'(acc_q[NW-1:0]);

`ifndef NO_ASSERTIONS
  a_prod_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword_i.op == OP_MUL_STEP && !zero_q) |-> prod_q < n_q)
    else $error("partial product not reduced below modulus");

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword_i.op == OP_EMIT && !zero_q) |-> acc_q < n_q)
    else $error("result not reduced below modulus");
`endif

endmodule
